// File: src/fbl_pkg.sv
// ----------------------------------------------------------------------------
// fbl_pkg
// Shared types, constants and the character code table for the text layout.
// ----------------------------------------------------------------------------
`default_nettype none
package fbl_pkg;

  localparam int GLYPH_COUNT = 256;
  localparam int GLYPH_W     = 8;
  localparam int CELL_W      = 7;
  localparam int SCALE_W     = 16;
  localparam int POS_W       = 24;
  localparam int RECT_W      = 22;
  localparam int TEX_W       = 10;
  localparam int SUM_W       = 17;
  localparam int TEXT_W      = 16;
  localparam int CODE_W      = 16;

  localparam logic [1:0] CMD_PIXEL = 2'd0;
  localparam logic [1:0] CMD_CHAR  = 2'd1;
  localparam logic [1:0] CMD_BEGIN = 2'd2;

  localparam logic [1:0] REG_CELL_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CELL_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE       = 2'd2;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef logic [CODE_W-1:0] code_tab_t [GLYPH_COUNT];

  localparam code_tab_t CODE_TABLE = '{
    16'h00c0, 16'h00c1, 16'h00c2, 16'h00c8, 16'h00ca, 16'h00cb, 16'h00cd, 16'h00d3,
    16'h00d4, 16'h00d5, 16'h00da, 16'h00df, 16'h00e3, 16'h00f5, 16'h011f, 16'h0131,
    16'h0131, 16'h0152, 16'h0153, 16'h015e, 16'h015f, 16'h0174, 16'h0175, 16'h017e,
    16'h0207, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025, 16'h0026, 16'h0027,
    16'h0028, 16'h0029, 16'h002a, 16'h002b, 16'h002c, 16'h002d, 16'h002e, 16'h002f,
    16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
    16'h0038, 16'h0039, 16'h003a, 16'h003b, 16'h003c, 16'h003d, 16'h003e, 16'h003f,
    16'h0040, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
    16'h0048, 16'h0049, 16'h004a, 16'h004b, 16'h004c, 16'h004d, 16'h004e, 16'h004f,
    16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
    16'h0058, 16'h0059, 16'h005a, 16'h005b, 16'h005c, 16'h005d, 16'h005e, 16'h005f,
    16'h0060, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
    16'h0068, 16'h0069, 16'h006a, 16'h006b, 16'h006c, 16'h006d, 16'h006e, 16'h006f,
    16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
    16'h0078, 16'h0079, 16'h007a, 16'h007b, 16'h007c, 16'h007d, 16'h007e, 16'h0000,
    16'h00c7, 16'h00fc, 16'h00e9, 16'h00e2, 16'h00e4, 16'h00e0, 16'h00e5, 16'h00e7,
    16'h00ea, 16'h00eb, 16'h00e8, 16'h00ef, 16'h00ee, 16'h00ec, 16'h00c4, 16'h00c5,
    16'h00c9, 16'h00e6, 16'h00c6, 16'h00f4, 16'h00f6, 16'h00f2, 16'h00fb, 16'h00f9,
    16'h00ff, 16'h00d6, 16'h00dc, 16'h00f8, 16'h00a3, 16'h00d8, 16'h00d7, 16'h0192,
    16'h00e1, 16'h00ed, 16'h00f3, 16'h00fa, 16'h00f1, 16'h00d1, 16'h00aa, 16'h00ba,
    16'h00bf, 16'h00ae, 16'h00ac, 16'h00bd, 16'h00bc, 16'h00a1, 16'h00ab, 16'h00bb,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255d, 16'h255c, 16'h255b, 16'h2510,
    16'h2514, 16'h2534, 16'h252c, 16'h251c, 16'h2500, 16'h253c, 16'h255e, 16'h255f,
    16'h255a, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256c, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256b,
    16'h256a, 16'h2518, 16'h250c, 16'h2588, 16'h2584, 16'h258c, 16'h2590, 16'h2580,
    16'h03b1, 16'h03b2, 16'h0393, 16'h03c0, 16'h03a3, 16'h03c3, 16'h03bc, 16'h03c4,
    16'h03a6, 16'h0398, 16'h03a9, 16'h03b4, 16'h221e, 16'h2205, 16'h2208, 16'h2229,
    16'h2261, 16'h00b1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00f7, 16'h2248,
    16'h00b0, 16'h2219, 16'h00b7, 16'h221a, 16'h207f, 16'h00b2, 16'h25a0, 16'h0000
  };

  typedef struct packed {
    logic               found;
    logic [GLYPH_W-1:0] index;
  } lookup_t;

  // First matching slot wins; empty slots never match.
  function automatic lookup_t find_glyph(input logic [CODE_W-1:0] code);
    lookup_t res;
    res = '0;
    for (int i = GLYPH_COUNT - 1; i >= 0; i--) begin
      if (CODE_TABLE[i] != '0 && CODE_TABLE[i] == code) begin
        res.found = 1'b1;
        res.index = GLYPH_W'(i);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: src/bitmap_font_text_layout.sv
// ----------------------------------------------------------------------------
// bitmap_font_text_layout
// Proportional bitmap-font engine: measures glyph widths from atlas pixels
// and lays out text characters with a saturating pen.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tuser cmd, tdata pixel/char/begin
//  out_    | out | out_tvalid/out_tready| tuser placed, tdata glyph placement
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  One item per cycle. An item is accepted and its glyph width read from the
//  width RAM in the same cycle; the second stage then merges, writes back
//  and forms the result, with forwarding when an item reads the width that
//  the item before it writes. Reset is synchronous and clears all widths
//  through per-entry valid bits. Output stalls hold the whole pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module bitmap_font_text_layout #(
  parameter int MAX_CELL = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  input  wire logic [1:0]   in_tuser,   // cmd
  // opaque, first_pixel, char_code, start_x, start_y
  input  wire logic [71:0]  in_tdata,
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  output      logic         out_tuser,  // placed
  // glyph_index, rect_x, rect_y, rect_w, rect_h, tex_x, tex_y,
  // glyph_width, text_width
  output      logic [143:0] out_tdata,
  input  wire logic         cfg_valid,
  output      logic         cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  localparam int CNT_W = $clog2(MAX_CELL);
  localparam int CW    = fbl_pkg::CELL_W;
  localparam int GW    = fbl_pkg::GLYPH_W;

  // configuration
  logic [CW-1:0]               cell_w_r, cell_h_r;
  logic [fbl_pkg::SCALE_W-1:0] scale_r;
  logic [CW-1:0]               cw, ch;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_w_r <= CW'(8);
      cell_h_r <= CW'(8);
      scale_r  <= 16'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fbl_pkg::REG_CELL_WIDTH:  cell_w_r <= cfg_data[CW-1:0];
        fbl_pkg::REG_CELL_HEIGHT: cell_h_r <= cfg_data[CW-1:0];
        fbl_pkg::REG_SCALE:       scale_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cw = cell_w_r;
    ch = cell_h_r;
    if (cw == '0) cw = CW'(1);
    if (cw > CW'(MAX_CELL)) cw = CW'(MAX_CELL);
    if (ch == '0) ch = CW'(1);
    if (ch > CW'(MAX_CELL)) ch = CW'(MAX_CELL);
  end

  // input fields
  logic [1:0]                  i_cmd;
  logic                        i_opq, i_first;
  logic [fbl_pkg::CODE_W-1:0]  i_code;
  logic [fbl_pkg::POS_W-1:0]   i_sx, i_sy;

  assign i_cmd   = in_tuser;
  assign i_opq   = in_tdata[0];
  assign i_first = in_tdata[1];
  assign i_code  = in_tdata[17:2];
  assign i_sx    = in_tdata[41:18];
  assign i_sy    = in_tdata[65:42];

  logic adv, acc;
  logic out_vld_r;
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;

  // raster counters
  logic [CNT_W-1:0] col_r, row_r, col_nxt, row_nxt, col_c, row_c;
  logic [3:0]       ccol_r, crow_r, ccol_c, crow_c, ccol_nxt, crow_nxt;
  logic [CW-1:0]    a_c;
  fbl_pkg::lookup_t a_lk;
  logic [GW-1:0]    a_g;

  always_comb begin
    col_c  = i_first ? '0 : col_r;
    row_c  = i_first ? '0 : row_r;
    ccol_c = i_first ? '0 : ccol_r;
    crow_c = i_first ? '0 : crow_r;
    if (CW'(col_c) >= cw) col_c = '0;
    if (CW'(row_c) >= ch) row_c = '0;
    a_c      = CW'(col_c) + CW'(1);
    col_nxt  = col_c;
    row_nxt  = row_c;
    ccol_nxt = ccol_c;
    crow_nxt = crow_c;
    if (a_c >= cw) begin
      col_nxt  = '0;
      ccol_nxt = ccol_c + 4'd1;
      if (ccol_c == 4'd15) begin
        if (CW'(row_c) + CW'(1) >= ch) begin
          row_nxt  = '0;
          crow_nxt = crow_c + 4'd1;
        end else begin
          row_nxt = row_c + CNT_W'(1);
        end
      end
    end else begin
      col_nxt = a_c[CNT_W-1:0];
    end
    a_lk = fbl_pkg::find_glyph(i_code);
    a_g  = (i_cmd == fbl_pkg::CMD_PIXEL) ? {crow_c, ccol_c} : a_lk.index;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ccol_r <= '0;
      crow_r <= '0;
    end else if (acc && i_cmd == fbl_pkg::CMD_PIXEL) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ccol_r <= ccol_nxt;
      crow_r <= crow_nxt;
    end
  end

  // second stage
  logic                      b_vld_r, b_opq_r, b_first_r, b_found_r;
  logic [1:0]                b_cmd_r;
  logic [GW-1:0]             b_g_r;
  logic [CW-1:0]             b_c_r;
  logic [fbl_pkg::POS_W-1:0] b_sx_r, b_sy_r;
  logic                      fwd_r;
  logic [CW-1:0]             fwd_d_r;
  logic [CW-1:0]             ram_q, b_w;
  logic [fbl_pkg::GLYPH_COUNT-1:0] vld_r, vld_nxt;
  logic                      b_pix, b_wr;

  always_comb begin
    if (!vld_r[b_g_r]) b_w = '0;
    else if (fwd_r)    b_w = fwd_d_r;
    else               b_w = ram_q;
  end

  assign b_pix = b_vld_r && b_cmd_r == fbl_pkg::CMD_PIXEL;
  assign b_wr  = adv && b_pix && b_opq_r && (b_first_r || b_c_r > b_w);

  always_comb begin
    vld_nxt = vld_r;
    if (b_pix && b_first_r) vld_nxt = '0;
    if (b_wr) vld_nxt[b_g_r] = 1'b1;
  end

  fbl_ram #(.WIDTH(CW), .DEPTH(fbl_pkg::GLYPH_COUNT)) u_widths (
    .clk   (clk),
    .we    (b_wr),
    .waddr (b_g_r),
    .wdata (b_c_r),
    .re    (adv),
    .raddr (a_g),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      fwd_r   <= 1'b0;
      vld_r   <= '0;
    end else if (adv) begin
      b_vld_r <= acc;
      fwd_r   <= b_wr && (b_g_r == a_g);
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_cmd_r   <= i_cmd;
      b_opq_r   <= i_opq;
      b_first_r <= i_first;
      b_found_r <= a_lk.found;
      b_g_r     <= a_g;
      b_c_r     <= a_c;
      b_sx_r    <= i_sx;
      b_sy_r    <= i_sy;
      fwd_d_r   <= b_c_r;
    end
  end

  // layout
  logic [fbl_pkg::POS_W-1:0]  pen_x_r, pen_y_r;
  logic [fbl_pkg::SUM_W-1:0]  wsum_r, wsum_nxt;
  logic [fbl_pkg::POS_W-1:0]  pen_x_nxt;
  logic [fbl_pkg::RECT_W-1:0] rw, rh;
  logic [fbl_pkg::POS_W:0]    pen_sum;
  logic [fbl_pkg::SUM_W:0]    ws_add;
  logic [fbl_pkg::SUM_W-1:0]  ws_cur;
  logic [fbl_pkg::TEXT_W-1:0] tw;
  logic [fbl_pkg::TEX_W-1:0]  tx, ty;
  logic                       b_place;

  always_comb begin
    b_place = b_vld_r && b_cmd_r == fbl_pkg::CMD_CHAR && b_found_r;
    rw      = fbl_pkg::RECT_W'(b_w * scale_r);
    rh      = fbl_pkg::RECT_W'(ch * scale_r);
    tx      = fbl_pkg::TEX_W'(b_g_r[3:0] * cw);
    ty      = fbl_pkg::TEX_W'(b_g_r[7:4] * ch);
    pen_sum = (fbl_pkg::POS_W+1)'(pen_x_r) + (fbl_pkg::POS_W+1)'(rw) + 25'd256;
    pen_x_nxt = pen_sum[fbl_pkg::POS_W] ? fbl_pkg::POS_MAX : pen_sum[fbl_pkg::POS_W-1:0];
    ws_add  = (fbl_pkg::SUM_W+1)'(wsum_r) + (fbl_pkg::SUM_W+1)'(b_w) + 18'd1;
    wsum_nxt = ws_add[fbl_pkg::SUM_W] ? fbl_pkg::SUM_MAX : ws_add[fbl_pkg::SUM_W-1:0];
    ws_cur  = b_place ? wsum_nxt : wsum_r;
    if (ws_cur == '0)                      tw = '0;
    else if (ws_cur - 17'd1 > 17'h0FFFF)   tw = '1;
    else                                   tw = fbl_pkg::TEXT_W'(ws_cur - 17'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
      wsum_r  <= '0;
    end else if (adv && b_vld_r) begin
      if (b_cmd_r == fbl_pkg::CMD_BEGIN) begin
        pen_x_r <= b_sx_r;
        pen_y_r <= b_sy_r;
        wsum_r  <= '0;
      end else if (b_place) begin
        pen_x_r <= pen_x_nxt;
        wsum_r  <= wsum_nxt;
      end
    end
  end

  // output register
  logic         out_placed_r;
  logic [143:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= b_vld_r && b_cmd_r == fbl_pkg::CMD_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_placed_r <= b_place;
      if (b_place) begin
        out_data_r <= {1'b0, tw, b_w, ty, tx, rh, rw, pen_y_r, pen_x_r, b_g_r};
      end else begin
        out_data_r <= {1'b0, tw, 127'd0};
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_placed_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// File: src/fbl_ram.sv
// ----------------------------------------------------------------------------
// fbl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module fbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: test/fbl_checker.sv
// ----------------------------------------------------------------------------
// fbl_checker
// Watches the pixel/char/begin input, configuration and placement output
// channels of the text layout block. Predicts each placement from its own
// copy of glyph widths, raster counters, pen and configuration, and compares
// every output transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fbl_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [1:0]   in_tuser,
  input  wire logic [71:0]  in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic         out_tuser,
  input  wire logic [143:0] out_tdata,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic                       placed;
    logic [fbl_pkg::TEXT_W-1:0] text_width;
    logic [6:0]                 glyph_width;
    logic [fbl_pkg::TEX_W-1:0]  tex_y;
    logic [fbl_pkg::TEX_W-1:0]  tex_x;
    logic [fbl_pkg::RECT_W-1:0] rect_h;
    logic [fbl_pkg::RECT_W-1:0] rect_w;
    logic [fbl_pkg::POS_W-1:0]  rect_y;
    logic [fbl_pkg::POS_W-1:0]  rect_x;
    logic [7:0]                 glyph_index;
  } placement_t;

  placement_t placements_due[$];

  logic [6:0]       widths [fbl_pkg::GLYPH_COUNT];
  int unsigned      col_in_cell, cell_col, row_in_cell, cell_row;
  int unsigned      pen_x, pen_y, width_sum;
  int unsigned      cell_w_reg, cell_h_reg, scale_reg;

  assign pending = placements_due.size();

  function automatic int unsigned clamp_cell(input int unsigned v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  function automatic int unsigned text_width_now();
    int unsigned t;
    t = (width_sum > 0) ? width_sum - 1 : 0;
    return (t > 65535) ? 65535 : t;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic model_reset();
    foreach (widths[i]) widths[i] = '0;
    col_in_cell = 0; cell_col = 0; row_in_cell = 0; cell_row = 0;
    pen_x = 0; pen_y = 0; width_sum = 0;
    cell_w_reg = 8; cell_h_reg = 8; scale_reg = 256;
    placements_due.delete();
  endtask

  task automatic take_pixel(input logic opq, input logic first);
    int unsigned cw, ch, g;
    cw = clamp_cell(cell_w_reg);
    ch = clamp_cell(cell_h_reg);
    if (first) begin
      foreach (widths[i]) widths[i] = '0;
      col_in_cell = 0; cell_col = 0; row_in_cell = 0; cell_row = 0;
    end
    if (col_in_cell >= cw) col_in_cell = 0;
    if (row_in_cell >= ch) row_in_cell = 0;
    g = ((cell_row & 15) << 4) | (cell_col & 15);
    if (opq && (col_in_cell + 1) > widths[g]) widths[g] = 7'(col_in_cell + 1);
    col_in_cell++;
    if (col_in_cell >= cw) begin
      col_in_cell = 0;
      cell_col = (cell_col + 1) & 15;
      if (cell_col == 0) begin
        row_in_cell++;
        if (row_in_cell >= ch) begin
          row_in_cell = 0;
          cell_row = (cell_row + 1) & 15;
        end
      end
    end
  endtask

  task automatic place_char(input logic [fbl_pkg::CODE_W-1:0] code);
    placement_t p;
    int gi, cw, ch;
    int unsigned w, rw, adv;
    gi = -1;
    p = '0;
    cw = clamp_cell(cell_w_reg);
    ch = clamp_cell(cell_h_reg);
    for (int i = 0; i < fbl_pkg::GLYPH_COUNT; i++)
      if (gi < 0 && fbl_pkg::CODE_TABLE[i] != '0 && fbl_pkg::CODE_TABLE[i] == code) gi = i;
    if (gi >= 0) begin
      w = widths[gi];
      rw = w * scale_reg;
      p.placed = 1'b1;
      p.glyph_index = 8'(gi);
      p.rect_x = fbl_pkg::POS_W'(pen_x);
      p.rect_y = fbl_pkg::POS_W'(pen_y);
      p.rect_w = fbl_pkg::RECT_W'(rw);
      p.rect_h = fbl_pkg::RECT_W'(ch * scale_reg);
      p.tex_x = fbl_pkg::TEX_W'((gi & 15) * cw);
      p.tex_y = fbl_pkg::TEX_W'((gi >> 4) * ch);
      p.glyph_width = 7'(w);
      adv = pen_x + rw + 256;
      pen_x = (adv > 32'hFFFFFF) ? 32'hFFFFFF : adv;
      width_sum += w + 1;
      if (width_sum > 32'h1FFFF) width_sum = 32'h1FFFF;
    end
    p.text_width = fbl_pkg::TEXT_W'(text_width_now());
    placements_due.insert(placements_due.size(), p);
  endtask

  always @(posedge clk) begin
    placement_t want, got;
    if (!rst_n) begin
      model_reset();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fbl_pkg::REG_CELL_WIDTH:  cell_w_reg = cfg_data[6:0];
          fbl_pkg::REG_CELL_HEIGHT: cell_h_reg = cfg_data[6:0];
          fbl_pkg::REG_SCALE:       scale_reg  = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[142:0]};
        if (placements_due.size() == 0) begin
          report("unexpected output transfer", got.placed, 0);
        end else begin
          want = placements_due.pop_front();
          if (got.placed != want.placed) report("placed", got.placed, want.placed);
          if (got.glyph_index != want.glyph_index)
            report("glyph_index", got.glyph_index, want.glyph_index);
          if (got.rect_x != want.rect_x) report("rect_x", got.rect_x, want.rect_x);
          if (got.rect_y != want.rect_y) report("rect_y", got.rect_y, want.rect_y);
          if (got.rect_w != want.rect_w) report("rect_w", got.rect_w, want.rect_w);
          if (got.rect_h != want.rect_h) report("rect_h", got.rect_h, want.rect_h);
          if (got.tex_x != want.tex_x) report("tex_x", got.tex_x, want.tex_x);
          if (got.tex_y != want.tex_y) report("tex_y", got.tex_y, want.tex_y);
          if (got.glyph_width != want.glyph_width)
            report("glyph_width", got.glyph_width, want.glyph_width);
          if (got.text_width != want.text_width)
            report("text_width", got.text_width, want.text_width);
        end
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          fbl_pkg::CMD_PIXEL: take_pixel(in_tdata[0], in_tdata[1]);
          fbl_pkg::CMD_CHAR:  place_char(in_tdata[17:2]);
          fbl_pkg::CMD_BEGIN: begin
            pen_x = in_tdata[41:18];
            pen_y = in_tdata[65:42];
            width_sum = 0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the text layout block: directed corner items, then random
// atlas runs, strings and noise over several cell sizes and scales, with
// random idling on both channels. Checking is done by fbl_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [1:0]   in_tuser;
  logic [71:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         out_tuser;
  logic [143:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_data;
  int           errors;
  int           pending;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           items_sent;
  longint       cycles = 0;

  bitmap_font_text_layout dut (.*);

  fbl_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic send(input logic [1:0] cmd, input logic opq, input logic first,
                      input logic [15:0] code, input logic [23:0] sx,
                      input logic [23:0] sy);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(3, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, sy, sx, code, first, opq};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (items_sent == 650) begin
      send_idle_pct = 83; recv_idle_pct = 36;
    end else if (items_sent == 1300) begin
      send_idle_pct = 0; recv_idle_pct = 0;
    end
  endtask

  task automatic send_rand(input logic [1:0] cmd, input logic opq, input logic first,
                           input logic [15:0] code);
    send(cmd, opq, first, code, 24'($urandom), 24'($urandom));
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] mapped_code();
    logic [15:0] c;
    c = '0;
    while (c == '0) c = fbl_pkg::CODE_TABLE[$urandom_range(fbl_pkg::GLYPH_COUNT - 1)];
    return c;
  endfunction

  task automatic random_burst(input int n_items);
    int done, run;
    logic [15:0] code;
    done = 0;
    while (done < n_items) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          run = $urandom_range(120, 4);
          send_rand(fbl_pkg::CMD_PIXEL, 1'($urandom_range(1)), 1'b1, 16'($urandom));
          for (int k = 1; k < run; k++)
            send_rand(fbl_pkg::CMD_PIXEL, ($urandom_range(3) == 0),
                      ($urandom_range(200) == 0), 16'($urandom));
          done += run;
        end
        3, 4, 5, 6, 7: begin
          run = $urandom_range(12, 1);
          if ($urandom_range(9) == 0)
            send(fbl_pkg::CMD_BEGIN, 1'($urandom_range(1)), 1'($urandom_range(1)),
                 16'($urandom), 24'hFFF000 | 24'($urandom_range(4095)), 24'($urandom));
          else
            send_rand(fbl_pkg::CMD_BEGIN, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      16'($urandom));
          for (int k = 0; k < run; k++) begin
            code = ($urandom_range(7) == 0) ? 16'($urandom) : mapped_code();
            send_rand(fbl_pkg::CMD_CHAR, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      code);
          end
          done += run + 1;
        end
        default: begin
          send_rand(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    ($urandom_range(1) == 1) ? mapped_code() : 16'($urandom));
          done += 1;
        end
      endcase
    end
  endtask

  initial begin
    logic [15:0] cw_set [6] = '{16'd1, 16'd3, 16'd64, 16'd0, 16'd2, 16'd127};
    logic [15:0] ch_set [6] = '{16'd1, 16'd2, 16'd1, 16'd127, 16'd3, 16'd0};
    logic [15:0] sc_set [6] = '{16'd1, 16'd256, 16'd65535, 16'd0, 16'd384, 16'hA5A5};
    items_sent = 0;
    send_idle_pct = 36;
    recv_idle_pct = 83;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults, unmapped and duplicate codes, saturation, noise
    send(fbl_pkg::CMD_CHAR, 1'b0, 1'b0, 16'h00c0, '0, '0);
    send(fbl_pkg::CMD_PIXEL, 1'b1, 1'b1, '0, '0, '0);
    for (int k = 0; k < 7; k++) send(fbl_pkg::CMD_PIXEL, (k == 6), 1'b0, '0, '0, '0);
    send(fbl_pkg::CMD_BEGIN, 1'b0, 1'b0, '0, 24'd0, 24'd0);
    send(fbl_pkg::CMD_CHAR, 1'b0, 1'b0, 16'h00c0, '0, '0);
    send(fbl_pkg::CMD_CHAR, 1'b0, 1'b0, 16'h0000, '0, '0);
    send(fbl_pkg::CMD_CHAR, 1'b0, 1'b1, 16'h0131, '0, '0);
    send(fbl_pkg::CMD_CHAR, 1'b1, 1'b0, 16'h25a0, '0, '0);
    send(fbl_pkg::CMD_CHAR, 1'b1, 1'b1, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send(2'd3, 1'b1, 1'b1, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send(fbl_pkg::CMD_BEGIN, 1'b1, 1'b1, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send(fbl_pkg::CMD_CHAR, 1'b0, 1'b0, 16'h00c0, '0, '0);
    send(fbl_pkg::CMD_CHAR, 1'b0, 1'b0, 16'h00c1, '0, '0);
    random_burst(300);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(fbl_pkg::REG_CELL_WIDTH, cw_set[p]);
      write_reg(fbl_pkg::REG_CELL_HEIGHT, ch_set[p]);
      write_reg(fbl_pkg::REG_SCALE, sc_set[p]);
      random_burst(270);
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
